### hdl/nss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nss_pkg
// Shared constants and types for the nearest segment search block.
// ----------------------------------------------------------------------------
package nss_pkg;

    localparam int VERTEX_SLOTS_DEF = 256;
    localparam int EDGE_SLOTS_DEF   = 512;
    localparam int COORD_BITS_DEF   = 12;
    localparam int NODE_BITS        = 8;
    localparam int ACTION_BITS      = 2;

    localparam logic [ACTION_BITS-1:0] ACT_VERTEX = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ACTION_BITS-1:0] ACT_QUERY  = 2'd3;

    typedef enum logic [1:0] {
        MAC_LOAD = 2'd0,
        MAC_ADD  = 2'd1,
        MAC_SUB  = 2'd2
    } mac_mode_t;

    typedef struct packed {
        logic      en;
        mac_mode_t mode;
        logic      shl;
    } mac_op_t;

endpackage
`default_nettype wire

### hdl/nearest_segment_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_segment_search
// Vertex table, edge list and a nearest segment query run on one shared MAC.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  req     | req_valid, req_stall | action, node_a, node_b, pos_x, pos_y
//  rsp     | rsp_valid, rsp_stall | found, near_first, near_second
//
//  Vertex write, edge append and edge clear are done in ST_IDLE and never stall.
//  A query with no edges goes straight to ST_FINISH; else per edge it passes
//  ST_E_ADDR, ST_P_RD, ST_S_RD, ST_DIFF, then 15 ST_MUL steps (the first edge skips the compare steps).
//  req_stall is high while a query runs; a finished query waits in
//  ST_FINISH, holding the block, only while the previous result is unread.
//  Reset (rst_n, async) empties the edge list; vertex contents are kept as
//  undefined until written.
// ----------------------------------------------------------------------------
module nearest_segment_search #(
    parameter int VERTEX_SLOTS = nss_pkg::VERTEX_SLOTS_DEF,
    parameter int EDGE_SLOTS   = nss_pkg::EDGE_SLOTS_DEF,
    parameter int COORD_BITS   = nss_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire logic [nss_pkg::ACTION_BITS-1:0]   action,
    input  wire logic [nss_pkg::NODE_BITS-1:0]     node_a,
    input  wire logic [nss_pkg::NODE_BITS-1:0]     node_b,
    input  wire logic signed [COORD_BITS-1:0]      pos_x,
    input  wire logic signed [COORD_BITS-1:0]      pos_y,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output logic                                   found,
    output logic [nss_pkg::NODE_BITS-1:0]          near_first,
    output logic [nss_pkg::NODE_BITS-1:0]          near_second
);

    localparam int C   = COORD_BITS;
    localparam int NB  = nss_pkg::NODE_BITS;
    localparam int VAW = $clog2(VERTEX_SLOTS);
    localparam int EAW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
    localparam int ECW = $clog2(EDGE_SLOTS + 1);
    localparam int DW  = 2 * C + 3;
    localparam int MW  = 2 * C + 4;
    localparam int SH  = 2 * C + 2;
    localparam int NW  = 4 * C + 4;
    localparam int AW  = 6 * C + 10;

    localparam logic [3:0] STEP_CROSS_A = 4'd0;
    localparam logic [3:0] STEP_CROSS_B = 4'd1;
    localparam logic [3:0] STEP_LEN_A   = 4'd2;
    localparam logic [3:0] STEP_LEN_B   = 4'd3;
    localparam logic [3:0] STEP_DOT_A   = 4'd4;
    localparam logic [3:0] STEP_DOT_B   = 4'd5;
    localparam logic [3:0] STEP_DOT_CAP = 4'd6;
    localparam logic [3:0] STEP_DIST_A  = 4'd7;
    localparam logic [3:0] STEP_DIST_B  = 4'd8;
    localparam logic [3:0] STEP_NUM_CAP = 4'd9;
    localparam logic [3:0] STEP_CMP_A   = 4'd10;
    localparam logic [3:0] STEP_CMP_B   = 4'd11;
    localparam logic [3:0] STEP_CMP_C   = 4'd12;
    localparam logic [3:0] STEP_CMP_D   = 4'd13;
    localparam logic [3:0] STEP_PICK    = 4'd14;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_E_ADDR = 7'b0000010,
        ST_P_RD   = 7'b0000100,
        ST_S_RD   = 7'b0001000,
        ST_DIFF   = 7'b0010000,
        ST_MUL    = 7'b0100000,
        ST_FINISH = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [3:0]       step_reg, step_next;
    logic [ECW-1:0]   edge_idx_reg, edge_idx_next;
    logic [ECW-1:0]   edges_held_reg, edges_held_next;
    logic             have_reg, have_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [NW-1:0]    best_num_reg, best_num_next;
    logic [DW-1:0]    best_den_reg, best_den_next;

    logic signed [C-1:0] qx_reg, qy_reg, px_reg, py_reg;
    logic [NB-1:0]       p_reg, s_reg, best_first_reg, best_second_reg;
    logic signed [C:0]   ax_reg, ay_reg, hx_reg, hy_reg, gx_reg, gy_reg;
    logic [MW-1:0]       c_reg;
    logic [DW-1:0]       len_reg, cur_den_reg;
    logic signed [MW-1:0] t_reg;
    logic [NW-1:0]       cur_num_reg;
    logic                found_reg;
    logic [NB-1:0]       near_first_reg, near_second_reg;

    logic                accept;
    logic                is_query;
    logic                append_ok;
    logic                vtx_wr;
    logic                edge_wr;
    logic [2*C-1:0]      vtx_rd_data;
    logic [2*NB-1:0]     edge_rd_data;
    logic [VAW-1:0]      vtx_rd_addr;
    logic                near_p, near_s;
    logic                out_free;
    logic                last_edge;
    logic                take;

    nss_pkg::mac_op_t     mac_op;
    logic signed [MW-1:0] opa, opb;
    logic signed [AW-1:0] acc;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign is_query  = (action == nss_pkg::ACT_QUERY);
    assign append_ok = (32'(edges_held_reg) < EDGE_SLOTS) && (32'(node_a) < VERTEX_SLOTS)
                       && (32'(node_b) < VERTEX_SLOTS);
    assign vtx_wr    = accept && (action == nss_pkg::ACT_VERTEX) && (32'(node_a) < VERTEX_SLOTS);
    assign edge_wr   = accept && (action == nss_pkg::ACT_APPEND) && append_ok;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign last_edge = ((edge_idx_reg + ECW'(1)) == edges_held_reg);

    // Clamp cases: at or before the first endpoint (or degenerate), at or past the second
    assign near_p = (len_reg == '0) || (t_reg <= 0);
    assign near_s = (t_reg >= $signed({1'b0, len_reg}));
    assign take   = !have_reg || acc[AW-1];

    assign vtx_rd_addr = (state_reg == ST_P_RD) ? VAW'(edge_rd_data[2*NB-1:NB]) : VAW'(s_reg);

    nss_ram #(
        .WIDTH (2 * C),
        .DEPTH (VERTEX_SLOTS)
    ) u_vtx_ram (
        .clk     (clk),
        .wr_en   (vtx_wr),
        .wr_addr (VAW'(node_a)),
        .wr_data ({pos_x, pos_y}),
        .rd_addr (vtx_rd_addr),
        .rd_data (vtx_rd_data)
    );

    nss_ram #(
        .WIDTH (2 * NB),
        .DEPTH (EDGE_SLOTS)
    ) u_edge_ram (
        .clk     (clk),
        .wr_en   (edge_wr),
        .wr_addr (edges_held_reg[EAW-1:0]),
        .wr_data ({node_a, node_b}),
        .rd_addr (edge_idx_reg[EAW-1:0]),
        .rd_data (edge_rd_data)
    );

    nss_mac #(
        .MW (MW),
        .AW (AW),
        .SH (SH)
    ) u_mac (
        .clk (clk),
        .op  (mac_op),
        .opa (opa),
        .opb (opb),
        .acc (acc)
    );

    // Multiplier schedule for one edge
    always_comb
    begin
        mac_op.en   = 1'b0;
        mac_op.mode = nss_pkg::MAC_LOAD;
        mac_op.shl  = 1'b0;
        opa         = '0;
        opb         = '0;
        if (state_reg == ST_MUL)
        begin
            case (step_reg)
                STEP_CROSS_A:
                begin
                    mac_op.en = 1'b1;
                    opa = MW'(ax_reg);
                    opb = MW'(hy_reg);
                end
                STEP_CROSS_B:
                begin
                    mac_op.en   = 1'b1;
                    mac_op.mode = nss_pkg::MAC_SUB;
                    opa = MW'(ay_reg);
                    opb = MW'(hx_reg);
                end
                STEP_LEN_A:
                begin
                    mac_op.en = 1'b1;
                    opa = MW'(ax_reg);
                    opb = MW'(ax_reg);
                end
                STEP_LEN_B:
                begin
                    mac_op.en   = 1'b1;
                    mac_op.mode = nss_pkg::MAC_ADD;
                    opa = MW'(ay_reg);
                    opb = MW'(ay_reg);
                end
                STEP_DOT_A:
                begin
                    mac_op.en = 1'b1;
                    opa = MW'(ax_reg);
                    opb = MW'(hx_reg);
                end
                STEP_DOT_B:
                begin
                    mac_op.en   = 1'b1;
                    mac_op.mode = nss_pkg::MAC_ADD;
                    opa = MW'(ay_reg);
                    opb = MW'(hy_reg);
                end
                STEP_DIST_A:
                begin
                    mac_op.en = 1'b1;
                    if (near_p)
                    begin
                        opa = MW'(hx_reg);
                        opb = MW'(hx_reg);
                    end
                    else if (near_s)
                    begin
                        opa = MW'(gx_reg);
                        opb = MW'(gx_reg);
                    end
                    else
                    begin
                        opa = $signed(c_reg);
                        opb = $signed(c_reg);
                    end
                end
                STEP_DIST_B:
                begin
                    mac_op.en   = 1'b1;
                    mac_op.mode = nss_pkg::MAC_ADD;
                    if (near_p)
                    begin
                        opa = MW'(hy_reg);
                        opb = MW'(hy_reg);
                    end
                    else if (near_s)
                    begin
                        opa = MW'(gy_reg);
                        opb = MW'(gy_reg);
                    end
                end
                // num * best_den - best_num * den, each wide factor in two halves
                STEP_CMP_A:
                begin
                    mac_op.en = 1'b1;
                    opa = $signed(MW'(cur_num_reg[SH-1:0]));
                    opb = $signed(MW'(best_den_reg));
                end
                STEP_CMP_B:
                begin
                    mac_op.en   = 1'b1;
                    mac_op.mode = nss_pkg::MAC_ADD;
                    mac_op.shl  = 1'b1;
                    opa = $signed(MW'(cur_num_reg[NW-1:SH]));
                    opb = $signed(MW'(best_den_reg));
                end
                STEP_CMP_C:
                begin
                    mac_op.en   = 1'b1;
                    mac_op.mode = nss_pkg::MAC_SUB;
                    opa = $signed(MW'(best_num_reg[SH-1:0]));
                    opb = $signed(MW'(cur_den_reg));
                end
                STEP_CMP_D:
                begin
                    mac_op.en   = 1'b1;
                    mac_op.mode = nss_pkg::MAC_SUB;
                    mac_op.shl  = 1'b1;
                    opa = $signed(MW'(best_num_reg[NW-1:SH]));
                    opb = $signed(MW'(cur_den_reg));
                end
                default:
                begin
                    mac_op.en = 1'b0;
                end
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        edge_idx_next   = edge_idx_reg;
        edges_held_next = edges_held_reg;
        have_next       = have_reg;
        rsp_valid_next  = rsp_valid_reg;
        best_num_next   = best_num_reg;
        best_den_next   = best_den_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        nss_pkg::ACT_APPEND:
                        begin
                            if (append_ok)
                            begin
                                edges_held_next = edges_held_reg + ECW'(1);
                            end
                        end
                        nss_pkg::ACT_CLEAR:
                        begin
                            edges_held_next = '0;
                        end
                        nss_pkg::ACT_QUERY:
                        begin
                            have_next     = 1'b0;
                            edge_idx_next = '0;
                            state_next    = (edges_held_reg == '0) ? ST_FINISH : ST_E_ADDR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_E_ADDR: state_next = ST_P_RD;
            ST_P_RD:   state_next = ST_S_RD;
            ST_S_RD:   state_next = ST_DIFF;
            ST_DIFF:
            begin
                state_next = ST_MUL;
                step_next  = STEP_CROSS_A;
            end
            ST_MUL:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == STEP_NUM_CAP && !have_reg)
                begin
                    step_next = STEP_PICK;
                end
                if (step_reg == STEP_PICK)
                begin
                    if (take)
                    begin
                        have_next     = 1'b1;
                        best_num_next = cur_num_reg;
                        best_den_next = cur_den_reg;
                    end
                    edge_idx_next = edge_idx_reg + ECW'(1);
                    state_next    = last_edge ? ST_FINISH : ST_E_ADDR;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= STEP_CROSS_A;
            edge_idx_reg   <= '0;
            edges_held_reg <= '0;
            have_reg       <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            best_num_reg   <= '0;
            best_den_reg   <= DW'(1);
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            edge_idx_reg   <= edge_idx_next;
            edges_held_reg <= edges_held_next;
            have_reg       <= have_next;
            rsp_valid_reg  <= rsp_valid_next;
            best_num_reg   <= best_num_next;
            best_den_reg   <= best_den_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && is_query)
        begin
            qx_reg <= pos_x;
            qy_reg <= pos_y;
        end
        if (state_reg == ST_P_RD)
        begin
            p_reg <= edge_rd_data[2*NB-1:NB];
            s_reg <= edge_rd_data[NB-1:0];
        end
        if (state_reg == ST_S_RD)
        begin
            px_reg <= vtx_rd_data[2*C-1:C];
            py_reg <= vtx_rd_data[C-1:0];
        end
        if (state_reg == ST_DIFF)
        begin
            ax_reg <= {vtx_rd_data[2*C-1], vtx_rd_data[2*C-1:C]} - {px_reg[C-1], px_reg};
            ay_reg <= {vtx_rd_data[C-1], vtx_rd_data[C-1:0]} - {py_reg[C-1], py_reg};
            hx_reg <= {qx_reg[C-1], qx_reg} - {px_reg[C-1], px_reg};
            hy_reg <= {qy_reg[C-1], qy_reg} - {py_reg[C-1], py_reg};
            gx_reg <= {qx_reg[C-1], qx_reg} - {vtx_rd_data[2*C-1], vtx_rd_data[2*C-1:C]};
            gy_reg <= {qy_reg[C-1], qy_reg} - {vtx_rd_data[C-1], vtx_rd_data[C-1:0]};
        end
        if (state_reg == ST_MUL)
        begin
            if (step_reg == STEP_LEN_A)
            begin
                c_reg <= MW'(acc[AW-1] ? -acc : acc);
            end
            if (step_reg == STEP_DOT_A)
            begin
                len_reg <= DW'(acc);
            end
            if (step_reg == STEP_DOT_CAP)
            begin
                t_reg <= MW'(acc);
            end
            if (step_reg == STEP_NUM_CAP)
            begin
                cur_num_reg <= NW'(acc);
                cur_den_reg <= (near_p || near_s) ? DW'(1) : len_reg;
            end
            if (step_reg == STEP_PICK && take)
            begin
                best_first_reg  <= p_reg;
                best_second_reg <= s_reg;
            end
        end
        if (state_reg == ST_FINISH && out_free)
        begin
            found_reg       <= have_reg;
            near_first_reg  <= have_reg ? best_first_reg : '0;
            near_second_reg <= have_reg ? best_second_reg : '0;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = found_reg;
    assign near_first  = near_first_reg;
    assign near_second = near_second_reg;

    a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(edges_held_reg) <= EDGE_SLOTS)
        else $error("edge count beyond capacity");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> step_reg <= STEP_PICK)
        else $error("sequencer step out of range");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (rsp_valid_reg && state_reg == ST_IDLE))
        else $error("finished query did not load result");

    a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_query && edges_held_reg == '0) |=> state_reg == ST_FINISH)
        else $error("query on empty list did not finish at once");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E_ADDR) |-> edge_idx_reg < edges_held_reg)
        else $error("edge walk past list end");

endmodule
`default_nettype wire

### hdl/nss_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                 clk,
    input  wire logic                                 wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                     wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### hdl/nss_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nss_mac
// Shared signed multiplier with shift and accumulate register.
// ----------------------------------------------------------------------------
module nss_mac #(
    parameter int MW = 28,
    parameter int AW = 82,
    parameter int SH = 26
) (
    input  wire logic                  clk,
    input  wire nss_pkg::mac_op_t      op,
    input  wire logic signed [MW-1:0]  opa,
    input  wire logic signed [MW-1:0]  opb,
    output logic signed      [AW-1:0]  acc
);

    logic signed [2*MW-1:0] prod;
    logic signed [AW-1:0]   ext;
    logic signed [AW-1:0]   term;
    logic signed [AW-1:0]   acc_next;

    always_comb
    begin
        prod = opa * opb;
        ext  = AW'(prod);
        term = op.shl ? (ext <<< SH) : ext;
        case (op.mode)
            nss_pkg::MAC_LOAD: acc_next = term;
            nss_pkg::MAC_ADD:  acc_next = acc + term;
            nss_pkg::MAC_SUB:  acc_next = acc - term;
            default:           acc_next = acc;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc <= acc_next;
        end
    end

endmodule
`default_nettype wire
